### rtl/tspf_pkg.sv
// shared types and constants for the two-stage average position filter
package tspf_pkg;

    // position and threshold widths in hundredths
    localparam int POS_W     = 7;
    localparam int THR_W     = 7;
    localparam int QUOT_W    = 7;
    localparam int SCALE_MUL = 200;

    localparam logic [POS_W-1:0] POS_FULL    = 7'd100;
    localparam logic [THR_W-1:0] THR_DEFAULT = 7'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PICK_THRESHOLD = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic scale;
        logic sample_div;
        logic store;
        logic walk_clr;
        logic walk;
        logic walk_avg;
        logic mean_start;
        logic avg_write;
        logic pick;
        logic out_load;
    } ctrl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic sat;
        logic div_done;
        logic walk_end;
        logic block_full;
        logic window_full;
    } dp_status_t;

endpackage

### rtl/tspf_ram.sv
// generic single-write, single-read memory with registered read data
module tspf_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 8
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic [WIDTH-1:0]          wdata,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/tspf_div.sv
// restoring divider, one quotient bit per cycle, seven-bit quotient
module tspf_div #(
    parameter int NUM_W = 20
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [NUM_W-1:0]           num,
    input  logic [NUM_W-1:0]           den,
    output logic                       busy,
    output logic                       done,
    output logic [tspf_pkg::QUOT_W-1:0] quot
);
    localparam int QW     = tspf_pkg::QUOT_W;
    localparam int STEP_W = $clog2(QW + 1);

    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dsh_reg;
    logic [QW-1:0]     quot_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              ge;

    assign ge = (rem_reg >= dsh_reg);

    // step counter and handshake flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(QW);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // shift-subtract datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            dsh_reg  <= den << (QW - 1);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quot_reg <= {quot_reg[QW-2:0], ge};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

    // a new division never starts over one in flight
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

### rtl/tspf_datapath.sv
// scaling, sample and average stores, walk accumulator and position pick
module tspf_datapath #(
    parameter int SAMPLES_PER_BLOCK   = 8,
    parameter int AVERAGES_PER_WINDOW = 8,
    parameter int ADC_BITS            = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tspf_pkg::ctrl_cmd_t           cmd,
    output tspf_pkg::dp_status_t          status,
    input  logic [ADC_BITS-1:0]           raw_sample,
    input  logic [ADC_BITS-1:0]           full_scale,
    input  logic [tspf_pkg::THR_W-1:0]    pick_threshold,
    output logic [tspf_pkg::POS_W-1:0]    position
);
    localparam int SPB     = SAMPLES_PER_BLOCK;
    localparam int AVW     = AVERAGES_PER_WINDOW;
    localparam int MAXN    = (SPB > AVW) ? SPB : AVW;
    localparam int SUM_W   = $clog2(100 * MAXN + 1);
    localparam int MEAN_W  = SUM_W + 2;
    localparam int SCALE_W = ADC_BITS + 8;
    localparam int NUM_W   = (SCALE_W > MEAN_W) ? SCALE_W : MEAN_W;
    localparam int CNT_W   = $clog2(MAXN + 1);
    localparam int SIDX_W  = $clog2(SPB);
    localparam int AIDX_W  = $clog2(AVW);
    localparam int PW      = tspf_pkg::POS_W;
    localparam int MEAN_K  = MEAN_W + $clog2(2 * MAXN);
    localparam int RCP_W   = MEAN_K + 1;
    localparam int PROD_W  = MEAN_W + RCP_W;
    localparam int RCP_BLK = ((1 << MEAN_K) + 2 * SPB - 1) / (2 * SPB);
    localparam int RCP_WIN = ((1 << MEAN_K) + 2 * AVW - 1) / (2 * AVW);

    logic [ADC_BITS-1:0] raw_reg;
    logic [PW-1:0]       sample_reg;
    logic [PW-1:0]       held_reg;
    logic [PW-1:0]       pos_reg;
    logic [SIDX_W-1:0]   sidx_reg;
    logic [AIDX_W-1:0]   aidx_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [PW-1:0]       lo_reg;
    logic [PW-1:0]       hi_reg;
    logic [PW-1:0]       mean_reg;
    logic                mean_done_reg;

    logic                sat;
    logic [NUM_W-1:0]    div_num;
    logic [NUM_W-1:0]    div_den;
    logic                div_start;
    logic                div_busy;
    logic                div_done;
    logic [PW-1:0]       quot;
    logic [MEAN_W-1:0]   mean_num;
    logic [RCP_W-1:0]    mean_rcp;
    logic [PROD_W-1:0]   mean_prod;
    logic [PW-1:0]       smp_rdata;
    logic [PW-1:0]       avg_rdata;
    logic [PW-1:0]       walk_data;
    logic [CNT_W-1:0]    walk_len;
    logic [PW:0]         gap;
    logic                block_full;
    logic                window_full;

    // saturation above full scale or with full scale zero
    assign sat = (full_scale == '0) || (raw_reg > full_scale);

    // divider operands for scaling the reading
    assign div_num = NUM_W'(raw_reg) * NUM_W'(tspf_pkg::SCALE_MUL) + NUM_W'(full_scale);
    assign div_den = NUM_W'(full_scale) << 1;

    assign div_start = cmd.scale && !sat;

    tspf_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (quot)
    );

    // rounded block or window mean by reciprocal multiplication
    assign mean_num  = cmd.walk_avg ? (MEAN_W'(sum_reg) << 1) + MEAN_W'(AVW)
                                    : (MEAN_W'(sum_reg) << 1) + MEAN_W'(SPB);
    assign mean_rcp  = cmd.walk_avg ? RCP_W'(RCP_WIN) : RCP_W'(RCP_BLK);
    assign mean_prod = PROD_W'(mean_num) * PROD_W'(mean_rcp);

    always_ff @(posedge clk)
    begin
        if (cmd.mean_start)
        begin
            mean_reg <= mean_prod[MEAN_K +: PW];
        end
    end

    // sample and block-average stores
    tspf_ram #(
        .WIDTH (PW),
        .DEPTH (SPB)
    ) u_sample_ram (
        .clk   (clk),
        .we    (cmd.store),
        .waddr (sidx_reg),
        .wdata (sample_reg),
        .raddr (cnt_reg[SIDX_W-1:0]),
        .rdata (smp_rdata)
    );

    tspf_ram #(
        .WIDTH (PW),
        .DEPTH (AVW)
    ) u_avg_ram (
        .clk   (clk),
        .we    (cmd.avg_write),
        .waddr (aidx_reg),
        .wdata (mean_reg),
        .raddr (cnt_reg[AIDX_W-1:0]),
        .rdata (avg_rdata)
    );

    assign walk_data   = cmd.walk_avg ? avg_rdata : smp_rdata;
    assign walk_len    = cmd.walk_avg ? CNT_W'(AVW) : CNT_W'(SPB);
    assign block_full  = (sidx_reg == SIDX_W'(SPB - 1));
    assign window_full = (aidx_reg == AIDX_W'(AVW - 1));

    // raw beat and scaled sample
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            raw_reg <= raw_sample;
        end
        if (cmd.scale && sat)
        begin
            sample_reg <= tspf_pkg::POS_FULL;
        end
        else if (cmd.sample_div)
        begin
            sample_reg <= quot;
        end
    end

    // gap between window mean and minimum
    assign gap = {1'b0, mean_reg} - {1'b0, lo_reg};

    // store indexes, walk counter and held position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            sidx_reg      <= '0;
            aidx_reg      <= '0;
            cnt_reg       <= '0;
            mean_done_reg <= 1'b0;
        end
        else
        begin
            mean_done_reg <= cmd.mean_start;
            if (cmd.store)
            begin
                if (held_reg == '0)
                begin
                    held_reg <= sample_reg;
                end
                sidx_reg <= block_full ? '0 : sidx_reg + SIDX_W'(1);
            end
            else if (cmd.pick)
            begin
                held_reg <= (gap <= {1'b0, pick_threshold}) ? lo_reg : hi_reg;
            end
            if (cmd.avg_write)
            begin
                aidx_reg <= window_full ? '0 : aidx_reg + AIDX_W'(1);
            end
            if (cmd.walk_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.walk && (cnt_reg != walk_len))
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // walk accumulator: sum, minimum and maximum of the read beats
    always_ff @(posedge clk)
    begin
        if (cmd.walk_clr)
        begin
            sum_reg <= '0;
        end
        else if (cmd.walk && (cnt_reg != '0))
        begin
            sum_reg <= sum_reg + SUM_W'(walk_data);
            if (cnt_reg == CNT_W'(1))
            begin
                lo_reg <= walk_data;
                hi_reg <= walk_data;
            end
            else
            begin
                if (walk_data < lo_reg)
                begin
                    lo_reg <= walk_data;
                end
                if (walk_data > hi_reg)
                begin
                    hi_reg <= walk_data;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pos_reg <= held_reg;
        end
    end

    assign position           = pos_reg;
    assign status.sat         = sat;
    assign status.div_done    = div_done || mean_done_reg;
    assign status.walk_end    = (cnt_reg == walk_len);
    assign status.block_full  = block_full;
    assign status.window_full = window_full;

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= tspf_pkg::POS_FULL)
        else $error("held position above full travel");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAXN))
        else $error("walk counter past store depth");

    a_mean_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sample_div || cmd.avg_write || cmd.pick) |-> !div_busy)
        else $error("quotient used while divider busy");

endmodule

### rtl/tspf_ctrl.sv
// controller state machine sequencing one item through the datapath
module tspf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tspf_pkg::ctrl_cmd_t   cmd,
    input  tspf_pkg::dp_status_t  status
);
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_SCALE = 13'b0000000000010,
        S_SWAIT = 13'b0000000000100,
        S_STORE = 13'b0000000001000,
        S_BWALK = 13'b0000000010000,
        S_BDIV  = 13'b0000000100000,
        S_BWAIT = 13'b0000001000000,
        S_BWR   = 13'b0000010000000,
        S_WWALK = 13'b0000100000000,
        S_WDIV  = 13'b0001000000000,
        S_WWAIT = 13'b0010000000000,
        S_PICK  = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   can_load;

    assign can_load = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // next state and datapath commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_SCALE;
                end
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = status.sat ? S_STORE : S_SWAIT;
            end
            S_SWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.sample_div = 1'b1;
                    state_next     = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.store = 1'b1;
                if (status.block_full)
                begin
                    cmd.walk_clr = 1'b1;
                    state_next   = S_BWALK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_BWALK:
            begin
                cmd.walk = 1'b1;
                if (status.walk_end)
                begin
                    state_next = S_BDIV;
                end
            end
            S_BDIV:
            begin
                cmd.mean_start = 1'b1;
                state_next     = S_BWAIT;
            end
            S_BWAIT:
            begin
                if (status.div_done)
                begin
                    state_next = S_BWR;
                end
            end
            S_BWR:
            begin
                cmd.avg_write = 1'b1;
                if (status.window_full)
                begin
                    cmd.walk_clr = 1'b1;
                    state_next   = S_WWALK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WWALK:
            begin
                cmd.walk     = 1'b1;
                cmd.walk_avg = 1'b1;
                if (status.walk_end)
                begin
                    state_next = S_WDIV;
                end
            end
            S_WDIV:
            begin
                cmd.mean_start = 1'b1;
                cmd.walk_avg   = 1'b1;
                state_next     = S_WWAIT;
            end
            S_WWAIT:
            begin
                cmd.walk_avg = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (can_load)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_DONE) && can_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second beat taken while an item is in work");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && can_load) |=> out_valid_reg)
        else $error("finished item did not reach the output register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> can_load)
        else $error("output register overwritten before taken");

endmodule

### rtl/two_stage_average_position_filter.sv
// top level of the two-stage average position filter
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//   in      | in_valid, in_ready, raw_sample            | in
//   out     | out_valid, out_ready, position            | out
//
// one item in work at a time; the seven-step divider that scales the reading
// sets most of the work on an item, and a reading that saturates skips it
// an item that closes a block also walks the sample store and multiplies for
// the block mean, one that closes the window does the same over the averages
// a finished result waits in the output register while the next beat is taken
// reset restores full_scale to all ones and pick_threshold to 2
module two_stage_average_position_filter #(
    parameter int SAMPLES_PER_BLOCK   = 8,
    parameter int AVERAGES_PER_WINDOW = 8,
    parameter int ADC_BITS            = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tspf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ADC_BITS-1:0]               cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ADC_BITS-1:0]               raw_sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tspf_pkg::POS_W-1:0]        position
);
    logic [ADC_BITS-1:0]          full_scale_reg;
    logic [tspf_pkg::THR_W-1:0]   pick_threshold_reg;
    tspf_pkg::ctrl_cmd_t          cmd;
    tspf_pkg::dp_status_t         status;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg     <= '1;
            pick_threshold_reg <= tspf_pkg::THR_DEFAULT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tspf_pkg::REG_FULL_SCALE:
                begin
                    full_scale_reg <= cfg_data;
                end
                tspf_pkg::REG_PICK_THRESHOLD:
                begin
                    pick_threshold_reg <= cfg_data[tspf_pkg::THR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    tspf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    tspf_datapath #(
        .SAMPLES_PER_BLOCK   (SAMPLES_PER_BLOCK),
        .AVERAGES_PER_WINDOW (AVERAGES_PER_WINDOW),
        .ADC_BITS            (ADC_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .raw_sample     (raw_sample),
        .full_scale     (full_scale_reg),
        .pick_threshold (pick_threshold_reg),
        .position       (position)
    );

endmodule
